FILE: rtl/absvc_pkg.sv
// Shared types and constants for the alpha/beta space vector compare block.
package absvc_pkg;

    localparam int VOLT_WIDTH     = 16;
    localparam int DUTY_FRAC_BITS = 16;
    localparam int SQ3_Q          = 24;
    localparam int SQ3_K_W        = 25;
    localparam logic [SQ3_K_W-1:0] SQ3_K = 25'd29058991;

    localparam int XW = VOLT_WIDTH + SQ3_K_W + 1;
    localparam int UW = XW - 1;
    localparam int DW = XW;

    localparam logic [15:0] PWM_PERIOD_RST = 16'd1000;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    typedef struct packed {
        logic signed [VOLT_WIDTH-1:0] v_alpha;
        logic signed [VOLT_WIDTH-1:0] v_beta;
        logic [VOLT_WIDTH-2:0]        dc_voltage;
    } t_in;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic [2:0]  sector_number;
        logic        limited;
    } t_out;

    typedef struct packed {
        logic [2:0]    sector;
        logic [UW-1:0] um;
        logic [UW-1:0] un;
        logic [DW-1:0] den;
    } t_act;

endpackage

FILE: rtl/absvc_sector.sv
// Front end: sector search and clamped active-time numerators, three stages.
module absvc_sector (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  absvc_pkg::t_in    i_cmd,
    output logic              o_valid,
    output absvc_pkg::t_act   o_act
);
    localparam int VW  = absvc_pkg::VOLT_WIDTH;
    localparam int XW  = absvc_pkg::XW;
    localparam int UW  = absvc_pkg::UW;
    localparam int DW  = absvc_pkg::DW;
    localparam int SQW = 2 * (VW + 1);

    // stage 1
    logic signed [VW:0]   n_ax, n_bx;
    logic [VW:0]          n_mag_a, n_mag_b;
    logic [VW-2:0]        n_ud;
    logic [SQW-1:0]       r_sq_a, r_sq_b;
    logic signed [XW-1:0] r_p, r_bq;
    logic                 r_a_pos, r_a_neg, r_b_pos, r_b_neg;
    logic [DW-1:0]        r_den1;
    logic                 r_v1;

    always_comb begin
        n_ax    = {i_cmd.v_alpha[VW-1], i_cmd.v_alpha};
        n_bx    = {i_cmd.v_beta[VW-1], i_cmd.v_beta};
        n_mag_a = n_ax[VW] ? $unsigned(-n_ax) : $unsigned(n_ax);
        n_mag_b = n_bx[VW] ? $unsigned(-n_bx) : $unsigned(n_bx);
        n_ud    = (i_cmd.dc_voltage == '0) ? (VW-1)'(1) : i_cmd.dc_voltage;
    end

    always_ff @(posedge i_clk) begin
        r_sq_a  <= n_mag_a * n_mag_a;
        r_sq_b  <= n_mag_b * n_mag_b;
        r_p     <= $signed({1'b0, absvc_pkg::SQ3_K}) * i_cmd.v_alpha;
        r_bq    <= {{(XW-VW-absvc_pkg::SQ3_Q){i_cmd.v_beta[VW-1]}}, i_cmd.v_beta,
                    {absvc_pkg::SQ3_Q{1'b0}}};
        r_a_pos <= !i_cmd.v_alpha[VW-1] && (i_cmd.v_alpha != '0);
        r_a_neg <= i_cmd.v_alpha[VW-1];
        r_b_pos <= !i_cmd.v_beta[VW-1] && (i_cmd.v_beta != '0);
        r_b_neg <= i_cmd.v_beta[VW-1];
        r_den1  <= {{(DW-VW+1-absvc_pkg::SQ3_Q-1){1'b0}}, n_ud,
                    {(absvc_pkg::SQ3_Q+1){1'b0}}};
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    // stage 2
    logic                 n_big;
    logic [2:0]           n_sec;
    logic signed [XW-1:0] n_xm, n_xn;
    logic [2:0]           r_sec2;
    logic signed [XW-1:0] r_xm, r_xn;
    logic [DW-1:0]        r_den2;
    logic                 r_v2;

    always_comb begin
        n_big = {2'b00, r_sq_b} > ({2'b00, r_sq_a} + {1'b0, r_sq_a, 1'b0});
        n_sec = absvc_pkg::SEC_1;
        n_xm  = '0;
        n_xn  = '0;
        if (r_a_pos && !r_b_neg && !n_big) begin
            n_sec = absvc_pkg::SEC_1; n_xm = r_p - r_bq; n_xn = r_bq <<< 1;
        end else if (r_b_pos && n_big) begin
            n_sec = absvc_pkg::SEC_2; n_xm = r_p + r_bq; n_xn = r_bq - r_p;
        end else if (r_a_neg && r_b_pos) begin
            n_sec = absvc_pkg::SEC_3; n_xm = r_bq <<< 1; n_xn = -r_p - r_bq;
        end else if (r_a_neg && !r_b_pos && !n_big) begin
            n_sec = absvc_pkg::SEC_4; n_xm = r_bq - r_p; n_xn = -(r_bq <<< 1);
        end else if (r_b_neg && n_big) begin
            n_sec = absvc_pkg::SEC_5; n_xm = -r_p - r_bq; n_xn = r_p - r_bq;
        end else if (r_a_pos && r_b_neg) begin
            n_sec = absvc_pkg::SEC_6; n_xm = -(r_bq <<< 1); n_xn = r_p + r_bq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec2 <= n_sec;
        r_xm   <= n_xm;
        r_xn   <= n_xn;
        r_den2 <= r_den1;
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    // stage 3: clamp rounding undershoot near sector edges
    absvc_pkg::t_act r_act;
    logic            r_v3;

    always_ff @(posedge i_clk) begin
        r_act.sector <= r_sec2;
        r_act.um     <= r_xm[XW-1] ? '0 : r_xm[UW-1:0];
        r_act.un     <= r_xn[XW-1] ? '0 : r_xn[UW-1:0];
        r_act.den    <= r_den2;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_act   = r_act;

endmodule

FILE: rtl/absvc_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
module absvc_div #(
    parameter int DW = absvc_pkg::DW,
    parameter int QW = absvc_pkg::DUTY_FRAC_BITS + 1
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q
);
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];

    always_ff @(posedge i_clk) begin
        if (i_num >= i_den) begin
            r_rem[0] <= i_num - i_den;
            r_q[0]   <= QW'(1);
        end else begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
        end
        r_den[0] <= i_den;
    end

    for (genvar k = 1; k < QW; k++) begin : g_step
        logic [DW:0] n_sh;
        logic [DW:0] n_diff;
        logic        n_ge;

        always_comb begin
            n_sh   = {r_rem[k-1], 1'b0};
            n_diff = n_sh - {1'b0, r_den[k-1]};
            n_ge   = n_sh >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? n_diff[DW-1:0] : n_sh[DW-1:0];
            r_den[k] <= r_den[k-1];
            r_q[k]   <= {r_q[k-1][QW-2:0], n_ge};
        end
    end

    assign o_q = r_q[QW-1];

endmodule

FILE: rtl/alpha_beta_svm_compare.sv
// Top level: two-level space vector PWM compare values from an alpha/beta command.
//
//  channel   ports                          beat taken when
//  command   i_start, o_busy, i_cmd         i_start && !o_busy
//  result    o_valid, o_result              o_valid (one cycle, no hold-off)
//  config    i_cfg_we, i_cfg_data           i_cfg_we
//
// One command per cycle, carried through the three divider chains of
// DUTY_FRAC_BITS + 1 stages plus six other stages.
// o_busy is always low. Synchronous reset clears the valid pipe and sets
// the period to 1000. The receiver cannot stall, so nothing waits in the pipe.
module alpha_beta_svm_compare #(
    parameter int DUTY_FRAC_BITS = absvc_pkg::DUTY_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  absvc_pkg::t_in   i_cmd,
    output logic             o_valid,
    output absvc_pkg::t_out  o_result,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data
);
    localparam int DW = absvc_pkg::DW;
    localparam int UW = absvc_pkg::UW;
    localparam int QW = DUTY_FRAC_BITS + 1;
    localparam int CW = DUTY_FRAC_BITS + 2;
    localparam int PW = 16 + CW;

    logic [15:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= absvc_pkg::PWM_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    assign o_busy = 1'b0;

    logic            w_act_v;
    absvc_pkg::t_act w_act;

    absvc_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_cmd   (i_cmd),
        .o_valid (w_act_v),
        .o_act   (w_act)
    );

    // limit test and divider operands
    logic [DW-1:0] n_sum;
    logic          n_lim;
    logic [DW-1:0] r_n1, r_d1, r_n2, r_d2, r_n3, r_d3;
    logic [2:0]    r_sec4;
    logic          r_lim4, r_v4;

    always_comb begin
        n_sum = {1'b0, w_act.um} + {1'b0, w_act.un};
        n_lim = n_sum >= w_act.den;
    end

    always_ff @(posedge i_clk) begin
        r_n1   <= {{(DW-UW){1'b0}}, w_act.um};
        r_d1   <= n_lim ? n_sum : w_act.den;
        r_n2   <= {{(DW-UW){1'b0}}, w_act.un};
        r_d2   <= w_act.den;
        r_n3   <= n_lim ? '0 : w_act.den - n_sum;
        r_d3   <= {w_act.den[DW-2:0], 1'b0};
        r_sec4 <= w_act.sector;
        r_lim4 <= n_lim;
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= w_act_v;
        end
    end

    logic [QW-1:0] w_q1, w_q2, w_q3;

    absvc_div #(.DW(DW), .QW(QW)) u_div_m (
        .i_clk (i_clk), .i_num (r_n1), .i_den (r_d1), .o_q (w_q1)
    );
    absvc_div #(.DW(DW), .QW(QW)) u_div_n (
        .i_clk (i_clk), .i_num (r_n2), .i_den (r_d2), .o_q (w_q2)
    );
    absvc_div #(.DW(DW), .QW(QW)) u_div_0 (
        .i_clk (i_clk), .i_num (r_n3), .i_den (r_d3), .o_q (w_q3)
    );

    // sideband alongside the dividers
    logic [2:0] r_sb_sec [QW];
    logic       r_sb_lim [QW];
    logic       r_sb_v   [QW];

    always_ff @(posedge i_clk) begin
        r_sb_sec[0] <= r_sec4;
        r_sb_lim[0] <= r_lim4;
        if (!i_rst_n) begin
            r_sb_v[0] <= 1'b0;
        end else begin
            r_sb_v[0] <= r_v4;
        end
    end

    for (genvar k = 1; k < QW; k++) begin : g_sb
        always_ff @(posedge i_clk) begin
            r_sb_sec[k] <= r_sb_sec[k-1];
            r_sb_lim[k] <= r_sb_lim[k-1];
            if (!i_rst_n) begin
                r_sb_v[k] <= 1'b0;
            end else begin
                r_sb_v[k] <= r_sb_v[k-1];
            end
        end
    end

    // duty sums per sector
    logic [CW-1:0] n_dm, n_dn, n_d0, n_full, n_ca, n_cb, n_cc;
    logic [CW-1:0] r_ca, r_cb, r_cc;
    logic [2:0]    r_sec5;
    logic          r_lim5, r_v5;

    always_comb begin
        n_dm = {1'b0, w_q1};
        if (r_sb_lim[QW-1]) begin
            n_dn = (CW'(1) << DUTY_FRAC_BITS) - n_dm;
            n_d0 = '0;
        end else begin
            n_dn = {1'b0, w_q2};
            n_d0 = {1'b0, w_q3};
        end
        n_full = n_dm + n_dn + n_d0;
        case (r_sb_sec[QW-1])
            absvc_pkg::SEC_1: begin n_ca = n_full;      n_cb = n_dn + n_d0; n_cc = n_d0;        end
            absvc_pkg::SEC_2: begin n_ca = n_dm + n_d0; n_cb = n_full;      n_cc = n_d0;        end
            absvc_pkg::SEC_3: begin n_ca = n_d0;        n_cb = n_full;      n_cc = n_dn + n_d0; end
            absvc_pkg::SEC_4: begin n_ca = n_d0;        n_cb = n_dm + n_d0; n_cc = n_full;      end
            absvc_pkg::SEC_5: begin n_ca = n_dn + n_d0; n_cb = n_d0;        n_cc = n_full;      end
            default:          begin n_ca = n_full;      n_cb = n_d0;        n_cc = n_dm + n_d0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ca   <= n_ca;
        r_cb   <= n_cb;
        r_cc   <= n_cc;
        r_sec5 <= r_sb_sec[QW-1];
        r_lim5 <= r_sb_lim[QW-1];
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_sb_v[QW-1];
        end
    end

    // period scaling, output register
    logic [PW-1:0] r_pa, r_pb, r_pc;
    logic [2:0]    r_sec6;
    logic          r_lim6, r_v6;

    always_ff @(posedge i_clk) begin
        r_pa   <= r_period * r_ca;
        r_pb   <= r_period * r_cb;
        r_pc   <= r_period * r_cc;
        r_sec6 <= r_sec5;
        r_lim6 <= r_lim5;
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
    end

    assign o_valid                = r_v6;
    assign o_result.compare_a     = r_pa[DUTY_FRAC_BITS+15:DUTY_FRAC_BITS];
    assign o_result.compare_b     = r_pb[DUTY_FRAC_BITS+15:DUTY_FRAC_BITS];
    assign o_result.compare_c     = r_pc[DUTY_FRAC_BITS+15:DUTY_FRAC_BITS];
    assign o_result.sector_number = r_sec6;
    assign o_result.limited       = r_lim6;

endmodule

FILE: rtl/absvc_chk.sv
// Port-level checker for the space vector compare block, with its bind.
module absvc_chk #(
    parameter int DUTY_FRAC_BITS = absvc_pkg::DUTY_FRAC_BITS
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_start,
    input logic            o_busy,
    input logic            o_valid,
    input absvc_pkg::t_out o_result,
    input logic            i_cfg_we,
    input logic [15:0]     i_cfg_data
);
    localparam int LAT = DUTY_FRAC_BITS + 7;
    localparam int CNW = $clog2(LAT + 1);

    logic [15:0]    r_per;
    logic [CNW-1:0] r_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per <= absvc_pkg::PWM_PERIOD_RST;
            r_age <= '0;
        end else begin
            if (i_cfg_we) begin
                r_per <= i_cfg_data;
            end
            if (r_age != CNW'(LAT)) begin
                r_age <= r_age + CNW'(1);
            end
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_age == CNW'(LAT)) |-> (o_valid == $past(i_start && !o_busy, LAT)))
        else $error("result beat count does not follow command beats");

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.sector_number >= absvc_pkg::SEC_1 &&
                     o_result.sector_number <= absvc_pkg::SEC_6))
        else $error("sector out of range");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.compare_a <= r_per && o_result.compare_b <= r_per &&
                     o_result.compare_c <= r_per))
        else $error("compare above period");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.limited) |-> (o_result.compare_a == '0 ||
            o_result.compare_b == '0 || o_result.compare_c == '0))
        else $error("limited beat without a zero phase");

endmodule

bind alpha_beta_svm_compare absvc_chk #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_absvc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_result   (o_result),
    .i_cfg_we   (i_cfg_we),
    .i_cfg_data (i_cfg_data)
);
